### sv/smps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_pkg: shared types and constants of the sink minimum potential search
// Register indexes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package smps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = 52;
    localparam int CNT_W     = 21;

    localparam logic [30:0] BOX_RESET = 31'(125 << FRAC_BITS);

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_Z    = 3'd2,
        REG_RADIUS      = 3'd3,
        REG_BOX_SIZE    = 3'd4,
        REG_WANTED_TYPE = 3'd5,
        REG_SINK_ID     = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic calc;      // stage 1 -> stage 2 (squares)
        logic accum;     // compare and accumulate
        logic div_start; // start the three dividers
        logic div_step;  // one quotient bit per cycle
        logic emit;      // fill output register and clear accumulators
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic div_done;
    } dp_sts_t;

endpackage

### sv/sink_min_potential_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sink_min_potential_search: lowest potential particle near a sink
// Streams particles, keeps the deepest qualifying one and the mean velocity.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_       in   tdata: index, pos xyz, id, potential, vel xyz; tuser: type
// m_       out  tdata: min_index, found, mean xyz, count, count_zero
// cfg_     in   cfg_index, cfg_data
// An item is captured with its offsets, squared, then accumulated; the next
// item is taken only after that. The last item then runs the divider (start,
// 52 quotient-bit steps, finish) and loads the output register.
// Synchronous active-low reset; no clearing pass. A stalled result holds
// the block only when the next result is ready.
// ----------------------------------------------------------------------------
module sink_min_potential_search (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // index[19:0] pos_x[51:20] pos_y[83:52] pos_z[115:84] particle_id[147:116]
    // potential[179:148] vel_x[211:180] vel_y[243:212] vel_z[275:244], zero fill
    input  logic [279:0] s_tdata,
    // particle_type[2:0]
    input  logic [2:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // min_index[19:0] min_found[20] mean_vel_x[52:21] mean_vel_y[84:53]
    // mean_vel_z[116:85] match_count[137:117] count_zero[138], zero fill
    output logic [143:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    smps_pkg::dp_cmd_t cmd;
    smps_pkg::dp_sts_t sts;
    logic out_busy;

    assign cfg_ready = 1'b1;

    smps_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .out_busy(out_busy), .sts(sts), .cmd(cmd)
    );

    smps_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .cmd(cmd), .sts(sts), .out_busy(out_busy), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

### sv/smps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_ctrl: sequencing controller
// Walks one item through load, evaluate, accumulate and, on the last item,
// the serial mean division and result hand-off.
// ----------------------------------------------------------------------------
module smps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                out_busy,
    input  smps_pkg::dp_sts_t   sts,
    output smps_pkg::dp_cmd_t   cmd
);

    smps_pkg::state_t state_reg, state_next;
    logic [1:0] ev_reg, ev_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smps_pkg::ST_IDLE;
            ev_reg    <= 2'd0;
        end else begin
            state_reg <= state_next;
            ev_reg    <= ev_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ev_next    = ev_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            smps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    ev_next    = 2'd0;
                    state_next = smps_pkg::ST_EVAL;
                end
            end
            smps_pkg::ST_EVAL: begin
                ev_next = ev_reg + 2'd1;
                if (ev_reg == 2'd0) begin
                    cmd.calc = 1'b1;
                end else begin
                    cmd.accum = 1'b1;
                    if (sts.last) begin
                        state_next = smps_pkg::ST_DIV;
                    end else begin
                        state_next = smps_pkg::ST_IDLE;
                    end
                end
            end
            smps_pkg::ST_DIV: begin
                if (ev_reg == 2'd2) begin
                    cmd.div_start = 1'b1;
                    ev_next       = 2'd3;
                end else if (sts.div_done) begin
                    state_next = smps_pkg::ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            smps_pkg::ST_OUT: begin
                // wait for the output register to free up
                if (!out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = smps_pkg::ST_IDLE;
                end
            end
            default: state_next = smps_pkg::ST_IDLE;
        endcase
    end

endmodule

### sv/smps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_dp: datapath
// Minimum-image offsets, squared distance test, minimum tracking, velocity
// sums, three restoring dividers and the output register.
// ----------------------------------------------------------------------------
module smps_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [279:0]        s_tdata,
    input  logic [2:0]          s_tuser,
    input  logic                s_tlast,
    input  smps_pkg::dp_cmd_t   cmd,
    output smps_pkg::dp_sts_t   sts,
    output logic                out_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [143:0]        m_tdata
);

    // configuration
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        rad_reg, box_reg;
    logic [2:0]         wtype_reg;
    logic [31:0]        sink_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            rad_reg <= '0; box_reg <= smps_pkg::BOX_RESET;
            wtype_reg <= '0; sink_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                smps_pkg::REG_CENTER_X:    cx_reg    <= cfg_data;
                smps_pkg::REG_CENTER_Y:    cy_reg    <= cfg_data;
                smps_pkg::REG_CENTER_Z:    cz_reg    <= cfg_data;
                smps_pkg::REG_RADIUS:      rad_reg   <= cfg_data[30:0];
                smps_pkg::REG_BOX_SIZE:    box_reg   <= cfg_data[30:0];
                smps_pkg::REG_WANTED_TYPE: wtype_reg <= cfg_data[2:0];
                smps_pkg::REG_SINK_ID:     sink_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [32:0] wrap_mag(input logic signed [31:0] c,
                                             input logic signed [31:0] p,
                                             input logic [30:0] box);
        logic signed [33:0] d;
        logic [33:0] m;
        begin
            d = 34'(c) - 34'(p);
            m = d[33] ? 34'(-d) : 34'(d);
            if ({m, 1'b0} > 35'(box)) begin
                if (!d[33] && d != 0) d = d - 34'(box);
                else d = d + 34'(box);
            end
            m = d[33] ? 34'(-d) : 34'(d);
            wrap_mag = {(m[33:31] != 3'd0), m[31:0]};
        end
    endfunction

    // wrapped offsets of the incoming item, captured with it
    logic [32:0] mx, my, mz;
    assign mx = wrap_mag(cx_reg, s_tdata[51:20], box_reg);
    assign my = wrap_mag(cy_reg, s_tdata[83:52], box_reg);
    assign mz = wrap_mag(cz_reg, s_tdata[115:84], box_reg);

    // captured item
    logic [19:0]        idx_reg;
    logic [32:0]        mx_reg, my_reg, mz_reg;
    logic signed [31:0] pot_reg, vx_reg, vy_reg, vz_reg;
    logic               tmatch_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg    <= s_tdata[19:0];
            mx_reg     <= mx;
            my_reg     <= my;
            mz_reg     <= mz;
            pot_reg    <= s_tdata[179:148];
            vx_reg     <= s_tdata[211:180];
            vy_reg     <= s_tdata[243:212];
            vz_reg     <= s_tdata[275:244];
            tmatch_reg <= (s_tuser == wtype_reg) || (s_tdata[147:116] == sink_reg);
            last_reg   <= s_tlast;
        end
    end

    // stage: squares
    logic [61:0] sqx_reg, sqy_reg, sqz_reg, rsq_reg;
    logic        far_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            sqx_reg <= mx_reg[30:0] * mx_reg[30:0];
            sqy_reg <= my_reg[30:0] * my_reg[30:0];
            sqz_reg <= mz_reg[30:0] * mz_reg[30:0];
            rsq_reg <= rad_reg * rad_reg;
            far_reg <= mx_reg[32] || my_reg[32] || mz_reg[32];
        end
    end

    logic hit;
    assign hit = tmatch_reg && !far_reg &&
                 ((64'(sqx_reg) + 64'(sqy_reg) + 64'(sqz_reg)) <= 64'(rsq_reg));

    // accumulators
    logic [19:0]              bidx_reg;
    logic signed [31:0]       bpot_reg;
    logic                     have_reg;
    logic [smps_pkg::SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [smps_pkg::CNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            bidx_reg <= '0; bpot_reg <= '0; have_reg <= 1'b0;
            sx_reg <= '0; sy_reg <= '0; sz_reg <= '0; cnt_reg <= '0;
        end else if (cmd.accum && hit) begin
            if (!have_reg || pot_reg < bpot_reg) begin
                bidx_reg <= idx_reg;
                bpot_reg <= pot_reg;
                have_reg <= 1'b1;
            end
            sx_reg  <= sx_reg + {{20{vx_reg[31]}}, vx_reg};
            sy_reg  <= sy_reg + {{20{vy_reg[31]}}, vy_reg};
            sz_reg  <= sz_reg + {{20{vz_reg[31]}}, vz_reg};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // serial dividers: magnitude of sum by count, one quotient bit a cycle
    logic [smps_pkg::SUM_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [smps_pkg::CNT_W:0]   rx_reg, ry_reg, rz_reg;
    logic [2:0]                 neg_reg;
    logic [5:0]                 step_reg;

    function automatic logic [smps_pkg::SUM_W-1:0] smag(
            input logic [smps_pkg::SUM_W-1:0] s);
        smag = s[smps_pkg::SUM_W-1] ? -s : s;
    endfunction

    function automatic logic [smps_pkg::CNT_W:0] div_rem(input logic [smps_pkg::CNT_W:0] r);
        div_rem = (r >= 22'(cnt_reg)) ? r - 22'(cnt_reg) : r;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qx_reg <= smag(sx_reg); qy_reg <= smag(sy_reg); qz_reg <= smag(sz_reg);
            rx_reg <= '0; ry_reg <= '0; rz_reg <= '0;
            neg_reg <= {sz_reg[51], sy_reg[51], sx_reg[51]};
            step_reg <= 6'(smps_pkg::SUM_W);
        end else if (cmd.div_step) begin
            step_reg <= step_reg - 6'd1;
            rx_reg <= div_rem({rx_reg[20:0], qx_reg[51]});
            ry_reg <= div_rem({ry_reg[20:0], qy_reg[51]});
            rz_reg <= div_rem({rz_reg[20:0], qz_reg[51]});
            qx_reg <= {qx_reg[50:0], ({rx_reg[20:0], qx_reg[51]} >= 22'(cnt_reg))};
            qy_reg <= {qy_reg[50:0], ({ry_reg[20:0], qy_reg[51]} >= 22'(cnt_reg))};
            qz_reg <= {qz_reg[50:0], ({rz_reg[20:0], qz_reg[51]} >= 22'(cnt_reg))};
        end
    end

    assign sts.div_done = (step_reg == 6'd0);
    assign sts.last     = last_reg;

    function automatic logic [31:0] sat_mean(input logic [51:0] q, input logic neg,
                                             input logic zero);
        begin
            if (zero) sat_mean = '0;
            else if (neg) sat_mean = (q > 52'h80000000) ? 32'h80000000 : 32'(-q);
            else sat_mean = (q > 52'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        end
    endfunction

    // output register
    logic         mv_reg;
    logic [143:0] md_reg;
    logic         cz;
    assign cz = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.emit) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            md_reg <= {5'd0, cz, cnt_reg,
                       sat_mean(qz_reg, neg_reg[2], cz),
                       sat_mean(qy_reg, neg_reg[1], cz),
                       sat_mean(qx_reg, neg_reg[0], cz),
                       have_reg, have_reg ? bidx_reg : 20'd0};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign out_busy = mv_reg && !m_tready;

endmodule

### sv/smps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smps_checker: port-level checks
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module smps_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    // an item is never taken in back-to-back cycles
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken twice in a row");

    // found and empty flags never agree
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20] != m_tdata[138]))
        else $error("found and count_zero agree");

    // empty set reports zero count
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[138] |-> (m_tdata[137:117] == 21'd0))
        else $error("count_zero with nonzero count");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

endmodule

bind sink_min_potential_search smps_checker u_smps_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
